// ===== src/mmbd_pkg.sv =====
// shared types, address map constants and queue sizing for the memory map bus decoder
`default_nettype none

package mmbd_pkg;

    // store sizes
    localparam int WORK_BANK_BYTES_DEF = 4096;
    localparam int HIGH_RAM_BYTES_DEF  = 128;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // address map boundaries
    localparam logic [15:0] BOOT_END      = 16'h0100;
    localparam logic [15:0] VRAM_BASE     = 16'h8000;
    localparam logic [15:0] XRAM_BASE     = 16'hA000;
    localparam logic [15:0] WRAM_BASE     = 16'hC000;
    localparam logic [15:0] OAM_BASE      = 16'hFE00;
    localparam logic [15:0] UNUSED_BASE   = 16'hFEA0;
    localparam logic [15:0] IO_BASE       = 16'hFF00;
    localparam logic [15:0] HRAM_BASE     = 16'hFF80;
    localparam logic [15:0] IE_ADDR       = 16'hFFFF;
    localparam logic [15:0] JOYPAD_ADDR   = 16'hFF00;
    localparam logic [15:0] DMA_ADDR      = 16'hFF46;
    localparam logic [15:0] BOOT_OFF_ADDR = 16'hFF50;
    localparam logic [15:0] PAGE_MASK     = 16'hF000;
    localparam logic [15:0] PAGE_C        = 16'hC000;
    localparam logic [15:0] PAGE_E        = 16'hE000;
    localparam logic [15:0] GROUP_MASK    = 16'h00F0;
    localparam logic [15:0] GROUP_VIDEO   = 16'h0040;
    localparam logic [15:0] GROUP_BOOT    = 16'h0050;
    localparam logic [7:0]  OPEN_BUS      = 8'hFF;

    // decoded target of one access
    typedef enum logic [2:0] {
        TGT_INTERNAL = 3'd0,
        TGT_BOOT     = 3'd1,
        TGT_CART     = 3'd2,
        TGT_VIDEO    = 3'd3,
        TGT_JOYPAD   = 3'd4,
        TGT_DMA      = 3'd5,
        TGT_IGNORED  = 3'd6
    } t_target;

    // internal store touched by the access
    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_LOW  = 2'd1,
        ST_HIGH = 2'd2,
        ST_HRAM = 2'd3
    } t_store;

    // classified access travelling from front to back
    typedef struct packed {
        t_target     target;
        logic [15:0] address;
        t_store      store;
        logic        wr;
        logic [7:0]  wdata;
        logic [7:0]  rdata;
        logic [7:0]  fwd;
    } t_cmd;

endpackage

`default_nettype wire

// ===== src/memory_map_bus_decoder.sv =====
// a transfer passes through the queue slot, the access stage register and the output register before it can leave
// one transfer per cycle while the queue has room and the receiver is ready; front and back end run independently
// the back end issues one access per cycle, unless the output stalls, to single-port work ram and high ram banks
// reset clears the queue and pipeline valids, sets boot mode and clears interrupt enable
// ram contents are undefined after reset and need no clearing pass
`default_nettype none

module memory_map_bus_decoder
    import mmbd_pkg::*;
#(
    parameter int WORK_BANK_BYTES = WORK_BANK_BYTES_DEF,
    parameter int HIGH_RAM_BYTES  = HIGH_RAM_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // address[15:0], write_data[23:16]
    input  wire logic [0:0]  s_axis_tuser,  // req_type[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // device_address[15:0], read_data[23:16], forward_data[31:24]
    output logic [2:0]       m_axis_tuser   // target[2:0]
);

    logic        push;
    t_cmd        front_cmd;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    t_cmd        q_cmd;
    t_target     out_target;
    logic [15:0] out_address;
    logic [7:0]  out_rdata;
    logic [7:0]  out_fwd;

    mmbd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_wr      (s_axis_tuser[0]),
        .i_address (s_axis_tdata[15:0]),
        .i_wdata   (s_axis_tdata[23:16]),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_cmd     (front_cmd)
    );

    mmbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    mmbd_back #(
        .WORK_BANK_BYTES (WORK_BANK_BYTES),
        .HIGH_RAM_BYTES  (HIGH_RAM_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_target  (out_target),
        .o_address (out_address),
        .o_rdata   (out_rdata),
        .o_fwd     (out_fwd)
    );

    assign m_axis_tdata = {out_fwd, out_rdata, out_address};
    assign m_axis_tuser = out_target;

endmodule

`default_nettype wire

// ===== src/mmbd_ram.sv =====
// generic single-port ram with registered read data
`default_nettype none

module mmbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one access per enabled cycle, read data held otherwise
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/mmbd_front.sv =====
// front end: accepts bus accesses, decodes the address map, owns boot mode and interrupt enable
`default_nettype none

module mmbd_front
    import mmbd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_wr,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_wdata,
    input  wire logic        i_q_full,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic        r_boot_mode;
    logic        n_boot_mode;
    logic [7:0]  r_ie;
    logic [7:0]  n_ie;
    t_target     tgt;
    t_store      store;
    logic [7:0]  rd;
    logic [15:0] page;
    logic [15:0] grp;
    logic        accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign o_push  = accept;
    assign page    = i_address & PAGE_MASK;
    assign grp     = i_address & GROUP_MASK;

    // address map decode
    always_comb begin
        tgt         = TGT_INTERNAL;
        store       = ST_NONE;
        rd          = 8'd0;
        n_boot_mode = r_boot_mode;
        n_ie        = r_ie;
        if (i_address < VRAM_BASE) begin
            tgt = (!i_wr && r_boot_mode && i_address < BOOT_END) ? TGT_BOOT : TGT_CART;
        end else if (i_address < XRAM_BASE) begin
            tgt = TGT_VIDEO;
        end else if (i_address < WRAM_BASE) begin
            tgt = TGT_CART;
        end else if (i_address < OAM_BASE) begin
            store = (page == PAGE_C || page == PAGE_E) ? ST_LOW : ST_HIGH;
        end else if (i_address < UNUSED_BASE) begin
            tgt = TGT_VIDEO;
        end else if (i_address < IO_BASE) begin
            if (i_wr) begin
                tgt = TGT_IGNORED;
            end else begin
                rd = OPEN_BUS;
            end
        end else if (i_address < HRAM_BASE) begin
            if (i_address == JOYPAD_ADDR) begin
                tgt = TGT_JOYPAD;
            end else if (grp == GROUP_VIDEO) begin
                tgt = (i_wr && i_address == DMA_ADDR) ? TGT_DMA : TGT_VIDEO;
            end else if (grp == GROUP_BOOT) begin
                if (i_wr) begin
                    if (i_address == BOOT_OFF_ADDR) begin
                        n_boot_mode = 1'b0;
                    end else begin
                        tgt = TGT_IGNORED;
                    end
                end else begin
                    rd = OPEN_BUS;
                end
            end else if (i_wr) begin
                tgt = TGT_IGNORED;
            end
        end else if (i_address < IE_ADDR) begin
            store = ST_HRAM;
        end else begin
            if (i_wr) begin
                n_ie = i_wdata;
            end else begin
                rd = r_ie;
            end
        end
    end

    // classified transfer for the queue
    always_comb begin
        o_cmd.target  = tgt;
        o_cmd.address = i_address;
        o_cmd.store   = store;
        o_cmd.wr      = i_wr;
        o_cmd.wdata   = i_wdata;
        o_cmd.rdata   = (!i_wr && tgt == TGT_INTERNAL) ? rd : 8'd0;
        case (tgt)
            TGT_CART, TGT_VIDEO, TGT_JOYPAD, TGT_DMA: o_cmd.fwd = i_wr ? i_wdata : 8'd0;
            default:                                  o_cmd.fwd = 8'd0;
        endcase
    end

    // boot mode and interrupt enable update in access order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_mode <= 1'b1;
            r_ie        <= 8'd0;
        end else if (accept) begin
            r_boot_mode <= n_boot_mode;
            r_ie        <= n_ie;
        end
    end

`ifndef SYNTH
    a_boot_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_wr && i_address == BOOT_OFF_ADDR |=> !r_boot_mode)
        else $error("boot mode not cleared by write to boot off register");
    a_boot_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$rose(r_boot_mode))
        else $error("boot mode set again without reset");
    a_ie_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_wr && i_address == IE_ADDR |=> r_ie == $past(i_wdata))
        else $error("interrupt enable write lost");
`endif

endmodule

`default_nettype wire

// ===== src/mmbd_queue.sv =====
// short fifo that decouples the decode front end from the store back end
`default_nettype none

module mmbd_queue
    import mmbd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_cmd      o_cmd
);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && !o_valid))
        else $error("queue overflow or underflow");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== src/mmbd_back.sv =====
// back end: performs the ram accesses and holds the result in the output register
`default_nettype none

module mmbd_back
    import mmbd_pkg::*;
#(
    parameter int WORK_BANK_BYTES = WORK_BANK_BYTES_DEF,
    parameter int HIGH_RAM_BYTES  = HIGH_RAM_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  wire t_cmd        i_q_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_target          o_target,
    output logic [15:0]      o_address,
    output logic [7:0]       o_rdata,
    output logic [7:0]       o_fwd
);

    localparam int WA = $clog2(WORK_BANK_BYTES);
    localparam int HA = $clog2(HIGH_RAM_BYTES);

    logic        r_s1_valid;
    t_cmd        r_s1_cmd;
    logic        r_out_valid;
    t_target     r_out_target;
    logic [15:0] r_out_address;
    logic [7:0]  r_out_rdata;
    logic [7:0]  r_out_fwd;
    logic        out_load;
    logic        s1_ready;
    logic        pop;
    logic [7:0]  low_q;
    logic [7:0]  high_q;
    logic [7:0]  hram_q;
    logic [7:0]  rdata_mux;

    assign out_load = !r_out_valid || i_ready;
    assign s1_ready = !r_s1_valid || out_load;
    assign pop      = i_q_valid && s1_ready;
    assign o_pop    = pop;

    // internal stores
    mmbd_ram #(.WIDTH(8), .DEPTH(WORK_BANK_BYTES)) u_low_wram (
        .i_clk   (i_clk),
        .i_en    (pop && i_q_cmd.store == ST_LOW),
        .i_we    (i_q_cmd.wr),
        .i_addr  (i_q_cmd.address[WA-1:0]),
        .i_wdata (i_q_cmd.wdata),
        .o_rdata (low_q)
    );

    mmbd_ram #(.WIDTH(8), .DEPTH(WORK_BANK_BYTES)) u_high_wram (
        .i_clk   (i_clk),
        .i_en    (pop && i_q_cmd.store == ST_HIGH),
        .i_we    (i_q_cmd.wr),
        .i_addr  (i_q_cmd.address[WA-1:0]),
        .i_wdata (i_q_cmd.wdata),
        .o_rdata (high_q)
    );

    mmbd_ram #(.WIDTH(8), .DEPTH(HIGH_RAM_BYTES)) u_hram (
        .i_clk   (i_clk),
        .i_en    (pop && i_q_cmd.store == ST_HRAM),
        .i_we    (i_q_cmd.wr),
        .i_addr  (i_q_cmd.address[HA-1:0]),
        .i_wdata (i_q_cmd.wdata),
        .o_rdata (hram_q)
    );

    // read data select for the access in flight
    always_comb begin
        rdata_mux = r_s1_cmd.rdata;
        if (!r_s1_cmd.wr) begin
            case (r_s1_cmd.store)
                ST_LOW:  rdata_mux = low_q;
                ST_HIGH: rdata_mux = high_q;
                ST_HRAM: rdata_mux = hram_q;
                default: rdata_mux = r_s1_cmd.rdata;
            endcase
        end
    end

    // access stage and output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= pop;
            end
            if (out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1_cmd <= i_q_cmd;
        end
        if (out_load && r_s1_valid) begin
            r_out_target  <= r_s1_cmd.target;
            r_out_address <= r_s1_cmd.address;
            r_out_rdata   <= rdata_mux;
            r_out_fwd     <= r_s1_cmd.fwd;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_target  = r_out_target;
    assign o_address = r_out_address;
    assign o_rdata   = r_out_rdata;
    assign o_fwd     = r_out_fwd;

`ifndef SYNTH
    a_fwd_external: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_fwd != 8'd0 |-> r_out_target != TGT_INTERNAL)
        else $error("forward data on an internally handled transfer");
    a_rdata_internal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_target != TGT_INTERNAL |-> r_out_rdata == 8'd0)
        else $error("read data on an external transfer");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_memory_map_bus_decoder.sv =====
// self-checking testbench for the memory map bus decoder: directed table, then random bus traffic
module tb_memory_map_bus_decoder;
    import mmbd_pkg::*;

    localparam int NUM_RANDOM    = 1122;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 200;
    localparam int BOOT_OFF_ITEM = 600;
    localparam int QUIET_FROM    = 800;
    localparam int QUIET_TO      = 880;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int NUM_DIRECTED  = 28;

    // one decoded bus access as it leaves the block
    typedef struct packed {
        t_target     target;
        logic [15:0] dev_addr;
        logic [7:0]  rdata;
        logic [7:0]  fwd;
    } bus_result_t;

    // directed access, with a typed expectation where fixed is set
    typedef struct packed {
        logic        wr;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        fixed;
        t_target     target;
        logic [7:0]  rdata;
        logic [7:0]  fwd;
    } access_row_t;

    localparam access_row_t ACCESS_TABLE [NUM_DIRECTED] = '{
        '{1'b0, 16'h0000, 8'h00, 1'b1, TGT_BOOT,     8'h00, 8'h00},
        '{1'b0, 16'h00FF, 8'h00, 1'b1, TGT_BOOT,     8'h00, 8'h00},
        '{1'b0, 16'h0100, 8'h00, 1'b1, TGT_CART,     8'h00, 8'h00},
        '{1'b1, 16'h0000, 8'hA5, 1'b1, TGT_CART,     8'h00, 8'hA5},
        '{1'b0, 16'h8000, 8'h00, 1'b1, TGT_VIDEO,    8'h00, 8'h00},
        '{1'b1, 16'h9FFF, 8'h5A, 1'b1, TGT_VIDEO,    8'h00, 8'h5A},
        '{1'b1, 16'hBFFF, 8'hFF, 1'b1, TGT_CART,     8'h00, 8'hFF},
        '{1'b1, 16'hC000, 8'h11, 1'b1, TGT_INTERNAL, 8'h00, 8'h00},
        '{1'b0, 16'hE000, 8'h00, 1'b0, TGT_INTERNAL, 8'h00, 8'h00},
        '{1'b1, 16'hFDFF, 8'h22, 1'b1, TGT_INTERNAL, 8'h00, 8'h00},
        '{1'b0, 16'hDDFF, 8'h00, 1'b0, TGT_INTERNAL, 8'h00, 8'h00},
        '{1'b0, 16'hFE9F, 8'h00, 1'b1, TGT_VIDEO,    8'h00, 8'h00},
        '{1'b0, 16'hFEA0, 8'h00, 1'b1, TGT_INTERNAL, 8'hFF, 8'h00},
        '{1'b1, 16'hFEFF, 8'h77, 1'b1, TGT_IGNORED,  8'h00, 8'h00},
        '{1'b0, 16'hFF00, 8'h00, 1'b1, TGT_JOYPAD,   8'h00, 8'h00},
        '{1'b1, 16'hFF00, 8'h30, 1'b1, TGT_JOYPAD,   8'h00, 8'h30},
        '{1'b0, 16'hFF01, 8'h00, 1'b1, TGT_INTERNAL, 8'h00, 8'h00},
        '{1'b1, 16'hFF4F, 8'h0C, 1'b1, TGT_VIDEO,    8'h00, 8'h0C},
        '{1'b1, 16'hFF46, 8'hC1, 1'b1, TGT_DMA,      8'h00, 8'hC1},
        '{1'b0, 16'hFF5F, 8'h00, 1'b1, TGT_INTERNAL, 8'hFF, 8'h00},
        '{1'b1, 16'hFF51, 8'h01, 1'b1, TGT_IGNORED,  8'h00, 8'h00},
        '{1'b1, 16'hFF80, 8'h00, 1'b0, TGT_INTERNAL, 8'h00, 8'h00},
        '{1'b1, 16'hFFFE, 8'hFF, 1'b0, TGT_INTERNAL, 8'h00, 8'h00},
        '{1'b0, 16'hFFFE, 8'h00, 1'b0, TGT_INTERNAL, 8'h00, 8'h00},
        '{1'b0, 16'hFFFF, 8'h00, 1'b1, TGT_INTERNAL, 8'h00, 8'h00},
        '{1'b1, 16'hFFFF, 8'h1F, 1'b0, TGT_INTERNAL, 8'h00, 8'h00},
        '{1'b0, 16'hFFFF, 8'h00, 1'b0, TGT_INTERNAL, 8'h00, 8'h00},
        '{1'b0, 16'hFF80, 8'h00, 1'b0, TGT_INTERNAL, 8'h00, 8'h00}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // address[15:0], write_data[23:16]
    logic [0:0]  s_axis_tuser;   // req_type[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // device_address[15:0], read_data[23:16], forward_data[31:24]
    logic [2:0]  m_axis_tuser;   // target[2:0]

    // testbench model of the decoder's stores
    logic [7:0] low_mem  [WORK_BANK_BYTES_DEF];
    logic [7:0] high_mem [WORK_BANK_BYTES_DEF];
    logic [7:0] hram_mem [HIGH_RAM_BYTES_DEF];
    logic [7:0] ie_reg;
    logic       boot_on;

    // entries written so far, so that stimulus never reads an empty entry
    bit low_seen  [WORK_BANK_BYTES_DEF];
    bit high_seen [WORK_BANK_BYTES_DEF];
    bit hram_seen [HIGH_RAM_BYTES_DEF];
    logic [15:0] ram_addrs [$];

    bus_result_t result_fifo [$];

    int  errors;
    int  n_accesses;
    int  n_writes;
    int  n_checked;
    int  cycles;
    int  stall_left;
    bit  hold_req;
    bit  in_hold;
    bit  quiet;

    memory_map_bus_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // which internal store an address lands in
    function automatic t_store store_of(input logic [15:0] a);
        if (a >= WRAM_BASE && a < OAM_BASE) begin
            return (a[12] == 1'b0) ? ST_LOW : ST_HIGH;
        end
        if (a >= HRAM_BASE && a < IE_ADDR) begin
            return ST_HRAM;
        end
        return ST_NONE;
    endfunction

    function automatic logic ram_readable(input logic [15:0] a);
        case (store_of(a))
            ST_LOW:  return low_seen[a[11:0]];
            ST_HIGH: return high_seen[a[11:0]];
            ST_HRAM: return hram_seen[a[6:0]];
            default: return 1'b1;
        endcase
    endfunction

    // idle length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 9);
        return $urandom_range(20, 50);
    endfunction

    function automatic int send_gap();
        if (quiet || in_hold) return 0;
        if ($urandom_range(0, 99) < 60) return 0;
        return idle_len();
    endfunction

    // decode one access against the address map and update the stores
    task automatic decode_access(input logic wr, input logic [15:0] a, input logic [7:0] d,
                                 output bus_result_t r);
        t_target    tgt;
        logic [7:0] rd;
        tgt = TGT_INTERNAL;
        rd  = 8'h00;
        if (a < VRAM_BASE) begin
            if (!wr && boot_on && a < BOOT_END) tgt = TGT_BOOT;
            else tgt = TGT_CART;
        end else if (a < XRAM_BASE) begin
            tgt = TGT_VIDEO;
        end else if (a < WRAM_BASE) begin
            tgt = TGT_CART;
        end else if (a < OAM_BASE) begin
            // c and e pages hit the low bank, d and f pages the high bank
            if (a[12] == 1'b0) begin
                if (wr) low_mem[a[11:0]] = d;
                else rd = low_mem[a[11:0]];
            end else begin
                if (wr) high_mem[a[11:0]] = d;
                else rd = high_mem[a[11:0]];
            end
        end else if (a < UNUSED_BASE) begin
            tgt = TGT_VIDEO;
        end else if (a < IO_BASE) begin
            if (wr) tgt = TGT_IGNORED;
            else rd = OPEN_BUS;
        end else if (a < HRAM_BASE) begin
            if (a == JOYPAD_ADDR) begin
                tgt = TGT_JOYPAD;
            end else if ((a & GROUP_MASK) == GROUP_VIDEO) begin
                if (wr && a == DMA_ADDR) tgt = TGT_DMA;
                else tgt = TGT_VIDEO;
            end else if ((a & GROUP_MASK) == GROUP_BOOT) begin
                if (!wr) rd = OPEN_BUS;
                else if (a == BOOT_OFF_ADDR) boot_on = 1'b0;
                else tgt = TGT_IGNORED;
            end else if (wr) begin
                tgt = TGT_IGNORED;
            end
        end else if (a < IE_ADDR) begin
            if (wr) hram_mem[a[6:0]] = d;
            else rd = hram_mem[a[6:0]];
        end else begin
            if (wr) ie_reg = d;
            else rd = ie_reg;
        end
        r.target   = tgt;
        r.dev_addr = a;
        r.rdata    = (!wr && tgt == TGT_INTERNAL) ? rd : 8'h00;
        r.fwd      = (wr && (tgt == TGT_CART || tgt == TGT_VIDEO || tgt == TGT_JOYPAD ||
                             tgt == TGT_DMA)) ? d : 8'h00;
    endtask

    // offer one access at a falling edge, wait for its transfer, then idle
    task automatic send_item(input logic wr, input logic [15:0] a, input logic [7:0] d,
                             input logic fixed, input bus_result_t fixed_res, input int gap);
        bus_result_t pred;
        t_store      st;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {d, a};
        s_axis_tuser  <= wr;
        st = store_of(a);
        if (wr && st != ST_NONE) begin
            case (st)
                ST_LOW:  low_seen[a[11:0]] = 1'b1;
                ST_HIGH: high_seen[a[11:0]] = 1'b1;
                default: hram_seen[a[6:0]] = 1'b1;
            endcase
            ram_addrs.push_back(a);
            if (ram_addrs.size() > 64) void'(ram_addrs.pop_front());
        end
        do @(posedge i_clk); while (!s_axis_tready);
        decode_access(wr, a, d, pred);
        result_fifo.push_back(fixed ? fixed_res : pred);
        n_accesses++;
        if (wr) n_writes++;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on result %0d: %s got 0x%0h, want 0x%0h",
                 n_checked, field, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        bus_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_fifo.size() == 0) begin
                report_mismatch("unexpected transfer", m_axis_tdata, 32'h0);
            end else begin
                want = result_fifo.pop_front();
                if (m_axis_tuser !== want.target)
                    report_mismatch("target", 32'(m_axis_tuser), 32'(want.target));
                if (m_axis_tdata[15:0] !== want.dev_addr)
                    report_mismatch("device_address", 32'(m_axis_tdata[15:0]),
                                    32'(want.dev_addr));
                if (m_axis_tdata[23:16] !== want.rdata)
                    report_mismatch("read_data", 32'(m_axis_tdata[23:16]), 32'(want.rdata));
                if (m_axis_tdata[31:24] !== want.fwd)
                    report_mismatch("forward_data", 32'(m_axis_tdata[31:24]), 32'(want.fwd));
            end
            n_checked++;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                in_hold    = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                in_hold = 1'b0;
                if (!quiet && $urandom_range(0, 99) < 20) begin
                    m_axis_tready <= 1'b0;
                    stall_left = idle_len() - 1;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // watchdog
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("end of test: mismatches");
        $finish;
    end

    // stimulus and end of run
    initial begin
        access_row_t row;
        bus_result_t row_res;
        int          pick;
        logic        wr;
        logic [15:0] a;
        logic [7:0]  d;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_rst_n       = 1'b0;
        boot_on       = 1'b1;
        ie_reg        = 8'h00;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            row     = ACCESS_TABLE[i];
            row_res = '{row.target, row.addr, row.rdata, row.fwd};
            send_item(row.wr, row.addr, row.data, row.fixed, row_res, send_gap());
        end

        // random part over all map regions, with ram writes followed by reads through either mirror
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i == HOLD_AT) hold_req = 1'b1;
            quiet = (i >= QUIET_FROM && i < QUIET_TO);
            pick  = $urandom_range(0, 99);
            wr    = 1'($urandom_range(0, 1));
            d     = 8'($urandom);
            a     = 16'($urandom);
            if (pick < 10) begin
                a = 16'($urandom_range(0, 16'h01FF));
            end else if (pick < 20) begin
                // whole address space
            end else if (pick < 30) begin
                a = 16'($urandom_range(16'h8000, 16'hBFFF));
            end else if (pick < 50) begin
                a  = 16'($urandom_range(16'hC000, 16'hFDFF));
                wr = 1'b1;
            end else if (pick < 65) begin
                wr = 1'b0;
                if (ram_addrs.size() > 0) begin
                    a = ram_addrs[$urandom_range(0, ram_addrs.size() - 1)];
                    if (store_of(a) != ST_HRAM && $urandom_range(0, 1) == 1) begin
                        if (a < 16'hE000) begin
                            if (a + 16'h2000 < OAM_BASE) a = a + 16'h2000;
                        end else begin
                            a = a - 16'h2000;
                        end
                    end
                end
            end else if (pick < 72) begin
                a = 16'($urandom_range(16'hFE00, 16'hFEFF));
            end else if (pick < 85) begin
                case ($urandom_range(0, 5))
                    0:       a = JOYPAD_ADDR;
                    1:       a = DMA_ADDR;
                    2:       a = BOOT_OFF_ADDR;
                    default: a = 16'($urandom_range(16'hFF00, 16'hFF7F));
                endcase
            end else if (pick < 95) begin
                a = 16'($urandom_range(16'hFF80, 16'hFFFF));
            end else begin
                a = IE_ADDR;
            end
            // never read an entry that holds nothing yet
            if (!wr && !ram_readable(a)) wr = 1'b1;
            // boot rom stays mapped for the first part of the run
            if (wr && a == BOOT_OFF_ADDR && i < BOOT_OFF_ITEM) wr = 1'b0;
            if (i == BOOT_OFF_ITEM) begin
                wr = 1'b1;
                a  = BOOT_OFF_ADDR;
            end
            send_item(wr, a, d, 1'b0, '0, send_gap());
        end
        quiet = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (result_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d accesses (%0d writes) over all map regions, %0d results checked",
                 n_accesses, n_writes, n_checked);
        $display("boot rom unmapped mid-run, one %0d-cycle output hold-off, %0d cycles total",
                 HOLD_CYCLES, cycles);
        if (errors == 0 && result_fifo.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/mmbd_pkg.sv
src/mmbd_ram.sv
src/mmbd_front.sv
src/mmbd_queue.sv
src/mmbd_back.sv
src/memory_map_bus_decoder.sv
sim/tb_memory_map_bus_decoder.sv
